FILE: rtl/core/afc_pkg.sv
`timescale 1ns / 1ps

package afc_pkg;

  // Store depth used when the top level is not overridden
  localparam int unsigned STORE_DEPTH_DEF = 256;

  // Most store writes that one received byte can cause
  localparam int unsigned MAX_WRITES = 5;

  // Frame format codes held in the mode register
  localparam logic [2:0] FMT_PAREN       = 3'd0;
  localparam logic [2:0] FMT_FIXED25     = 3'd1;
  localparam logic [2:0] FMT_CRLF        = 3'd2;
  localparam logic [2:0] FMT_DOLLAR      = 3'd3;
  localparam logic [2:0] FMT_LFCR        = 3'd4;
  localparam logic [2:0] FMT_DIGITS      = 3'd5;
  localparam logic [2:0] FMT_DIGITS_ZERO = 3'd6;

  // Characters that the recognizers look for
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_IDLE   = 8'hFF;
  localparam logic [7:0] MASK7     = 8'h7F;

  // Frame geometry
  localparam logic [7:0] PAREN_LEN       = 8'd32;
  localparam logic [7:0] PAREN_CLOSE_IDX = 8'd30;
  localparam logic [7:0] PAREN_MAX_IDX   = 8'd35;
  localparam logic [7:0] FIX_LEN         = 8'd24;
  localparam logic [7:0] CRLF_MIN_IDX    = 8'd10;
  localparam logic [7:0] DOLLAR_CUT_IDX  = 8'd65;
  localparam logic [7:0] DOLLAR_MAX_IDX  = 8'd76;
  localparam logic [7:0] LFCR_LEN        = 8'd147;
  localparam logic [7:0] DIG_WRAP_IDX    = 8'd30;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } afc_state_e;

  // Byte that belongs to a digit reading
  function automatic logic is_digit_item(logic [7:0] d);
    return ((d >= CH_ZERO) && (d <= CH_NINE)) || (d == CH_DOT) || (d == CH_CR);
  endfunction

endpackage

FILE: rtl/core/analyzer_frame_capture.sv
`timescale 1ns / 1ps

// An accepted byte passes the holding register, working byte and write list to the output register.
// Each byte then takes an evaluation step, one request per store write (0 to 5) and a status request;
//   the single store write port and the one-deep output register set this, and out_ready_i can stall it.
// A byte may be accepted while the previous one is still being evaluated or emitted.
// Reset (async, active low): index, zero mark and mode go to 0, the per-entry valid bits
//   clear so the whole store reads as zero at once; no clearing pass is needed.
module analyzer_frame_capture #(
  parameter int unsigned STORE_DEPTH = afc_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // mode register
  input  logic       format_mode_we_i,
  input  logic [2:0] format_mode_i,
  // byte request
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  // result request
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       write_enable_o,
  output logic [7:0] write_address_o,
  output logic [7:0] write_data_o,
  output logic       frame_done_o,
  output logic [7:0] frame_length_o,
  output logic       frame_cancel_o,
  output logic       last_of_run_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned NW = afc_pkg::MAX_WRITES;
  localparam logic [8:0]  DepthW = 9'(STORE_DEPTH);

  // position lies inside the store
  function automatic logic in_rng(logic [7:0] a);
    return {1'b0, a} < DepthW;
  endfunction

  // Control and architectural state
  afc_pkg::afc_state_e state_q, state_d;
  logic [2:0] mode_q;
  logic [7:0] idx_q, idx_d;
  logic       zps_q, zps_d;
  logic       in_full_q;
  logic [7:0] in_byte_q;
  logic [7:0] byte_q;

  // Frame store, its valid bits and a mirror of the four lowest entries
  logic [7:0]             store_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_q;
  logic [7:0]             low_q [4];

  // Read port results
  logic [7:0] rd_a_raw_q, rd_b_raw_q;
  logic       rd_a_ok_q, rd_b_ok_q;
  logic [7:0] rd_a, rd_b;
  logic [7:0] idx_eff, addr_a, addr_b;

  // Pending write list and status
  logic [7:0] wl_addr_q [NW];
  logic [7:0] wl_data_q [NW];
  logic [7:0] wl_addr_d [NW];
  logic [7:0] wl_data_d [NW];
  logic [2:0] wcnt_q, wcnt_d;
  logic       done_q, done_d;
  logic [7:0] len_q, len_d;
  logic       cancel_q, cancel_d;

  // Output register
  logic       out_valid_q;
  logic       owe_q, odone_q, ocancel_q, olast_q;
  logic [7:0] oaddr_q, odata_q, olen_q;

  // Sequencer strobes
  logic push, start, eval_en, wr_push;

  // Evaluation scratch
  logic [7:0] iw, r0, m7, a1, a2;
  logic       w2;
  logic [7:0] ev [4];
  logic [2:0] wp;

  // Sequencer outputs
  always_comb begin
    push    = (state_q == afc_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
    wr_push = push && (wcnt_q != 3'd0);
    start   = in_full_q && ((state_q == afc_pkg::ST_IDLE) || (push && (wcnt_q == 3'd0)));
    eval_en = (state_q == afc_pkg::ST_EVAL);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afc_pkg::ST_IDLE: begin
        if (start) state_d = afc_pkg::ST_EVAL;
      end
      afc_pkg::ST_EVAL: begin
        state_d = afc_pkg::ST_EMIT;
      end
      afc_pkg::ST_EMIT: begin
        if (push && (wcnt_q == 3'd0)) begin
          state_d = start ? afc_pkg::ST_EVAL : afc_pkg::ST_IDLE;
        end
      end
      default: state_d = afc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o = !in_full_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afc_pkg::ST_IDLE;
      mode_q      <= afc_pkg::FMT_PAREN;
      idx_q       <= 8'd0;
      zps_q       <= 1'b0;
      in_full_q   <= 1'b0;
      wcnt_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (format_mode_we_i) mode_q <= format_mode_i;
      if (eval_en) begin
        idx_q <= idx_d;
        zps_q <= zps_d;
      end
      if (in_valid_i && in_ready_o) in_full_q <= 1'b1;
      else if (start)               in_full_q <= 1'b0;
      if (eval_en)      wcnt_q <= wcnt_d;
      else if (wr_push) wcnt_q <= wcnt_q - 3'd1;
      if (push)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Input holding register and working byte
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= data_byte_i;
    if (start)                    byte_q    <= in_byte_q;
  end

  // Look-back addresses; digit modes restart at the wrap index first
  always_comb begin
    idx_eff = idx_q;
    if (((mode_q == afc_pkg::FMT_DIGITS) || (mode_q == afc_pkg::FMT_DIGITS_ZERO)) &&
        (idx_q == afc_pkg::DIG_WRAP_IDX)) begin
      idx_eff = 8'd0;
    end
    addr_a = idx_eff - 8'd1;
    addr_b = idx_eff - 8'd4;
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_push) store_q[wl_addr_q[0][AW-1:0]] <= wl_data_q[0];
    if (start) begin
      rd_a_raw_q <= store_q[addr_a[AW-1:0]];
      rd_b_raw_q <= store_q[addr_b[AW-1:0]];
    end
  end

  // Valid bits, read qualifiers and low-entry mirror
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_a_ok_q <= 1'b0;
      rd_b_ok_q <= 1'b0;
      for (int k = 0; k < 4; k++) low_q[k] <= 8'd0;
    end else begin
      if (wr_push) begin
        valid_q[wl_addr_q[0][AW-1:0]] <= 1'b1;
        if (wl_addr_q[0] < 8'd4) low_q[wl_addr_q[0][1:0]] <= wl_data_q[0];
      end
      if (start) begin
        rd_a_ok_q <= in_rng(addr_a) && valid_q[addr_a[AW-1:0]];
        rd_b_ok_q <= in_rng(addr_b) && valid_q[addr_b[AW-1:0]];
      end
    end
  end

  assign rd_a = rd_a_ok_q ? rd_a_raw_q : 8'd0;
  assign rd_b = rd_b_ok_q ? rd_b_raw_q : 8'd0;

  // Frame recognizer: next index, zero mark, ordered write list and status
  always_comb begin
    idx_d    = idx_q;
    zps_d    = zps_q;
    done_d   = 1'b0;
    len_d    = 8'd0;
    cancel_d = 1'b0;
    wp       = 3'd0;
    for (int k = 0; k < NW; k++) begin
      wl_addr_d[k] = 8'd0;
      wl_data_d[k] = 8'd0;
    end
    m7 = byte_q & afc_pkg::MASK7;
    iw = idx_q;
    r0 = low_q[0];
    a1 = idx_eff - 8'd1;
    a2 = idx_eff - 8'd2;
    w2 = (idx_eff >= 8'd4) && (rd_b == afc_pkg::CH_DOT) && (byte_q == afc_pkg::CH_LF);
    // low entries as seen after the CR and decimal clears
    for (int k = 0; k < 4; k++) begin
      ev[k] = ((a1 == 8'(k)) || (w2 && (a2 == 8'(k)))) ? 8'd0 : low_q[k];
    end

    case (mode_q)
      afc_pkg::FMT_PAREN: begin
        if (m7 == afc_pkg::CH_LPAREN) begin
          cancel_d = 1'b1;
          idx_d    = 8'd1;
          wl_addr_d[wp] = 8'd0; wl_data_d[wp] = m7; wp = wp + 3'd1;
        end else begin
          if (idx_q > afc_pkg::PAREN_MAX_IDX) begin
            iw       = 8'd0;
            cancel_d = 1'b1;
          end
          if (in_rng(iw)) begin
            wl_addr_d[wp] = iw; wl_data_d[wp] = m7; wp = wp + 3'd1;
          end
          r0 = (iw == 8'd0) ? m7 : low_q[0];
          if ((r0 == afc_pkg::CH_LPAREN) && (m7 == afc_pkg::CH_RPAREN) &&
              (iw == afc_pkg::PAREN_CLOSE_IDX)) begin
            done_d = 1'b1;
            len_d  = afc_pkg::PAREN_LEN;
            iw     = 8'd0;
          end
          idx_d = iw + 8'd1;
        end
      end

      afc_pkg::FMT_FIXED25: begin
        if (in_rng(idx_q)) begin
          wl_addr_d[wp] = idx_q; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
        end
        if (idx_q == afc_pkg::FIX_LEN) begin
          done_d = 1'b1;
          len_d  = afc_pkg::FIX_LEN;
          idx_d  = 8'd0;
        end else if (idx_q > afc_pkg::FIX_LEN) begin
          idx_d    = 8'd0;
          cancel_d = 1'b1;
        end else begin
          idx_d = idx_q + 8'd1;
        end
      end

      afc_pkg::FMT_CRLF: begin
        if ((byte_q == afc_pkg::CH_F) || (byte_q == afc_pkg::CH_HASH)) begin
          cancel_d = 1'b1;
          idx_d    = 8'd1;
          wl_addr_d[wp] = 8'd0; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
        end else if ((byte_q != afc_pkg::CH_IDLE) &&
                     ((low_q[0] == afc_pkg::CH_F) || (low_q[0] == afc_pkg::CH_HASH))) begin
          if (in_rng(idx_q)) begin
            wl_addr_d[wp] = idx_q; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
          end
          if ((idx_q > afc_pkg::CRLF_MIN_IDX) && (rd_a == afc_pkg::CH_CR) &&
              (byte_q == afc_pkg::CH_LF)) begin
            done_d = 1'b1;
            len_d  = idx_q;
            idx_d  = 8'd0;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end
      end

      afc_pkg::FMT_DOLLAR: begin
        if (byte_q == afc_pkg::CH_DOLLAR) begin
          cancel_d = 1'b1;
          idx_d    = 8'd1;
          wl_addr_d[wp] = 8'd0; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
        end else if ((byte_q != afc_pkg::CH_IDLE) && (low_q[0] == afc_pkg::CH_DOLLAR)) begin
          if (in_rng(idx_q)) begin
            wl_addr_d[wp] = idx_q; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
          end
          // entry 0 may just have been overwritten
          r0 = (idx_q == 8'd0) ? byte_q : low_q[0];
          if ((r0 == afc_pkg::CH_DOLLAR) && (idx_q >= 8'd1) &&
              (rd_a == afc_pkg::CH_CR) && (byte_q == afc_pkg::CH_LF)) begin
            done_d = 1'b1;
            len_d  = idx_q;
            iw     = 8'd0;
          end else if ((r0 == afc_pkg::CH_DOLLAR) && (idx_q > afc_pkg::DOLLAR_CUT_IDX)) begin
            done_d = 1'b1;
            len_d  = idx_q;
            iw     = 8'd0;
          end else if (idx_q > afc_pkg::DOLLAR_MAX_IDX) begin
            iw = 8'd0;
          end
          idx_d = iw + 8'd1;
        end else begin
          idx_d = 8'd0;
        end
      end

      afc_pkg::FMT_LFCR: begin
        if ((byte_q == afc_pkg::CH_LF) && (idx_q == 8'd0)) begin
          cancel_d = 1'b1;
          iw       = 8'd1;
          wl_addr_d[wp] = 8'd0; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
        end else if ((byte_q == afc_pkg::CH_CR) && (idx_q == 8'd1) &&
                     (low_q[0] == afc_pkg::CH_LF)) begin
          iw = 8'd2;
          wl_addr_d[wp] = 8'd1; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
        end else if ((byte_q != afc_pkg::CH_IDLE) && (idx_q < afc_pkg::LFCR_LEN) &&
                     (idx_q >= 8'd2)) begin
          if (in_rng(idx_q)) begin
            wl_addr_d[wp] = idx_q; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
          end
          iw = idx_q + 8'd1;
        end else begin
          iw = 8'd0;
        end
        if (iw == afc_pkg::LFCR_LEN) begin
          done_d = 1'b1;
          len_d  = afc_pkg::LFCR_LEN;
          iw     = 8'd0;
        end
        idx_d = iw;
      end

      afc_pkg::FMT_DIGITS, afc_pkg::FMT_DIGITS_ZERO: begin
        iw = idx_eff;
        if ((byte_q == afc_pkg::CH_QUEST) || (byte_q == afc_pkg::CH_PCT)) begin
          iw    = 8'd0;
          zps_d = 1'b0;
        end else if (afc_pkg::is_digit_item(byte_q)) begin
          if (in_rng(iw)) begin
            wl_addr_d[wp] = iw; wl_data_d[wp] = byte_q; wp = wp + 3'd1;
          end
          iw = iw + 8'd1;
        end else if (byte_q == afc_pkg::CH_LF) begin
          if ((iw >= 8'd1) && (rd_a == afc_pkg::CH_CR)) begin
            // clear the CR, and the last digit after a decimal point
            if (in_rng(a1)) begin
              wl_addr_d[wp] = a1; wl_data_d[wp] = 8'd0; wp = wp + 3'd1;
            end
            if (w2 && in_rng(a2)) begin
              wl_addr_d[wp] = a2; wl_data_d[wp] = 8'd0; wp = wp + 3'd1;
            end
            if (mode_q == afc_pkg::FMT_DIGITS_ZERO) begin
              if ((ev[0] == afc_pkg::CH_ZERO) && (ev[1] == afc_pkg::CH_ZERO) &&
                  (ev[2] == afc_pkg::CH_ZERO) && (ev[3] == afc_pkg::CH_ZERO)) begin
                cancel_d = 1'b1;
                iw       = 8'd0;
                zps_d    = 1'b1;
              end else if (zps_q) begin
                // reading after a zero prefix: reformat as dd.d
                wl_addr_d[wp] = 8'd4; wl_data_d[wp] = 8'd0;           wp = wp + 3'd1;
                wl_addr_d[wp] = 8'd3; wl_data_d[wp] = ev[2];          wp = wp + 3'd1;
                wl_addr_d[wp] = 8'd2; wl_data_d[wp] = afc_pkg::CH_DOT; wp = wp + 3'd1;
                done_d = 1'b1;
                len_d  = iw;
                zps_d  = 1'b0;
                iw     = 8'd0;
              end
            end else begin
              done_d = 1'b1;
              len_d  = iw;
              iw     = 8'd0;
            end
          end
        end
        idx_d = iw;
      end

      default: begin
        idx_d = idx_q;
      end
    endcase
    wcnt_d = wp;
  end

  // Write list: loaded on evaluation, shifted out one write per request
  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      for (int k = 0; k < NW; k++) begin
        wl_addr_q[k] <= wl_addr_d[k];
        wl_data_q[k] <= wl_data_d[k];
      end
      done_q   <= done_d;
      len_q    <= len_d;
      cancel_q <= cancel_d;
    end else if (wr_push) begin
      for (int k = 0; k < NW - 1; k++) begin
        wl_addr_q[k] <= wl_addr_q[k+1];
        wl_data_q[k] <= wl_data_q[k+1];
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      owe_q     <= wr_push;
      oaddr_q   <= wr_push ? wl_addr_q[0] : 8'd0;
      odata_q   <= wr_push ? wl_data_q[0] : 8'd0;
      odone_q   <= wr_push ? 1'b0 : done_q;
      olen_q    <= (wr_push || !done_q) ? 8'd0 : len_q;
      ocancel_q <= wr_push ? 1'b0 : cancel_q;
      olast_q   <= !wr_push;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = owe_q;
  assign write_address_o = oaddr_q;
  assign write_data_o    = odata_q;
  assign frame_done_o    = odone_q;
  assign frame_length_o  = olen_q;
  assign frame_cancel_o  = ocancel_q;
  assign last_of_run_o   = olast_q;

  // Checks
  a_wr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_push |-> in_rng(wl_addr_q[0]))
    else $error("store write beyond depth");

  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_en |-> (wcnt_d <= 3'(NW)))
    else $error("write list overflow");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afc_pkg::ST_IDLE) |-> (wcnt_q == 3'd0))
    else $error("writes left pending while idle");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (wcnt_q == 3'd0)) |=> (out_valid_o && last_of_run_o && !write_enable_o))
    else $error("status request not presented");

  a_no_mid_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && (state_q == afc_pkg::ST_EMIT)) |-> (wcnt_q == 3'd0))
    else $error("next byte started before writes finished");

endmodule
